// File: sv/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared types and constants for the varint length-prefix deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vlpd_pkg;

  // deframer phase
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } vlpd_phase_t;

  // one result on its way from front to back
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       frame_error;
  } vlpd_item_t;

  // last length byte slot; a continuation in this slot is a prefix error
  localparam logic [2:0] LAST_PREFIX = 3'd4;

endpackage

// File: sv/vlpd_front.sv
// ----------------------------------------------------------------------------
// vlpd_front
// Accepts stream bytes, decodes the varint length prefix and tags payload
// bytes; results are pushed into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlpd_front
  import vlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] stream_byte,
  output logic       byte_stall,
  input  logic       queue_full,
  output logic       push_valid,
  output vlpd_item_t push_item
);

  vlpd_phase_t phase, phase_next;
  logic [31:0] length_accum, length_accum_next;
  logic [2:0]  prefix_count, prefix_count_next;
  logic [30:0] bytes_left, bytes_left_next;

  logic        accept;
  logic [31:0] group_bits;
  logic [31:0] merged;
  logic [30:0] left_dec;
  logic        prefix_error;

  // one byte per transfer whenever the queue has room
  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  // place the low 7 bits (low 4 bits for the fifth byte) of this length byte at its group position
  always_comb begin
    case (prefix_count)
      3'd0:    group_bits = {25'd0, stream_byte[6:0]};
      3'd1:    group_bits = {18'd0, stream_byte[6:0], 7'd0};
      3'd2:    group_bits = {11'd0, stream_byte[6:0], 14'd0};
      3'd3:    group_bits = {4'd0, stream_byte[6:0], 21'd0};
      3'd4:    group_bits = {stream_byte[3:0], 28'd0};
      default: group_bits = 32'd0;
    endcase
  end

  assign merged   = length_accum | group_bits;
  assign left_dec = bytes_left - 31'd1;

  // bad prefix: fifth byte continues, or completed length has bit 31 set
  assign prefix_error = stream_byte[7] ? (prefix_count >= LAST_PREFIX) : merged[31];

  // next state
  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    prefix_count_next = prefix_count;
    bytes_left_next   = bytes_left;
    if (accept) begin
      case (phase)
        PH_LENGTH: begin
          if (prefix_error) begin
            phase_next        = PH_HALTED;
            length_accum_next = 32'd0;
            prefix_count_next = 3'd0;
            bytes_left_next   = 31'd0;
          end else if (stream_byte[7]) begin
            length_accum_next = merged;
            prefix_count_next = prefix_count + 3'd1;
          end else begin
            length_accum_next = 32'd0;
            prefix_count_next = 3'd0;
            // zero length is dropped without a packet
            if (merged != 32'd0) begin
              bytes_left_next = merged[30:0];
              phase_next      = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = left_dec;
          if (left_dec == 31'd0) begin
            phase_next = PH_LENGTH;
          end
        end
        default: begin
          // halted: bytes are swallowed until reset
        end
      endcase
    end
  end

  // results
  always_comb begin
    push_valid = 1'b0;
    push_item  = '0;
    if (accept) begin
      case (phase)
        PH_LENGTH: begin
          if (prefix_error) begin
            push_valid            = 1'b1;
            push_item.frame_error = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push_valid             = 1'b1;
          push_item.payload_byte = stream_byte;
          push_item.packet_end   = (left_dec == 31'd0);
        end
        default: begin
          push_valid = 1'b0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      length_accum <= 32'd0;
      prefix_count <= 3'd0;
      bytes_left   <= 31'd0;
    end else begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      prefix_count <= prefix_count_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

// File: sv/vlpd_queue.sv
// ----------------------------------------------------------------------------
// vlpd_queue
// Small result queue between the front and the back so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlpd_queue
  import vlpd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  vlpd_item_t push_item,
  output logic       full,
  output logic       pop_valid,
  output vlpd_item_t pop_item,
  input  logic       pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  vlpd_item_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full      = (count == FULL_COUNT);
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/vlpd_back.sv
// ----------------------------------------------------------------------------
// vlpd_back
// Output register stage: presents one result at a time and refills from
// the queue when it is empty or whenever the held result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlpd_back
  import vlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  input  vlpd_item_t pop_item,
  output logic       pop_ready,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] payload_byte,
  output logic       packet_end,
  output logic       frame_error
);

  vlpd_item_t held;
  logic       load;

  // refill when empty or when the held result is transferred
  assign pop_ready = !result_valid || !result_stall;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop_ready) begin
      result_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= pop_item;
    end
  end

  assign payload_byte = held.payload_byte;
  assign packet_end   = held.packet_end;
  assign frame_error  = held.frame_error;

endmodule

// File: sv/varint_length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer
// Splits a byte stream into packets framed by a base-128 varint length.
//
// Input channel: one stream byte per transfer (byte_valid / byte_stall).
// Each packet opens with a one to five byte length, low group first; the
// payload bytes that follow leave on the result channel (result_valid /
// result_stall), the final one with packet_end set. A zero length gives no
// packet. A fifth length byte that continues, or a length with bit 31 set,
// gives one result with frame_error set; the block then swallows all bytes
// until reset.
// Throughput: one byte per cycle on both sides while neither side stalls.
// A payload byte is written to the queue at its own transfer edge and is
// loaded into the output register once no earlier result is ahead of it and
// the output register is free. byte_stall rises only when the
// QUEUE_DEPTH-entry result queue is full, so a stalled receiver blocks the
// input once that queue and the output register have filled.
// Reset (rst, synchronous) returns to length decoding and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module varint_length_prefix_deframer
  import vlpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] stream_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] payload_byte,
  output logic       packet_end,
  output logic       frame_error
);

  logic       push_valid;
  vlpd_item_t push_item;
  logic       queue_full;
  logic       pop_valid;
  vlpd_item_t pop_item;
  logic       pop_ready;

  // length decode and payload tagging
  vlpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .stream_byte (stream_byte),
    .byte_stall  (byte_stall),
    .queue_full  (queue_full),
    .push_valid  (push_valid),
    .push_item   (push_item)
  );

  // decoupling queue
  vlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // output register
  vlpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .pop_ready    (pop_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .payload_byte (payload_byte),
    .packet_end   (packet_end),
    .frame_error  (frame_error)
  );

endmodule
